// File: sv/key_value_table_store_defines.svh
// Assertion macros for the key/value table store.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef KEY_VALUE_TABLE_STORE_DEFINES_SVH
`define KEY_VALUE_TABLE_STORE_DEFINES_SVH

`ifndef SYNTHESIS
`define KVTS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KVTS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KVTS_ASSERT(label, clk, rst, prop, msg)
`define KVTS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: sv/kvts_pkg.sv
// Shared types and constants for the key/value table store.
// No dependencies; imported by the interfaces, the RAM users and the top level.
package kvts_pkg;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int KEY_BYTES_DEF   = 16;
  localparam int MAX_KEY_BYTES   = 16;

  localparam int REQ_W     = 2;
  localparam int KEY_WORD_W = 64;
  localparam int VALUE_W   = 64;
  localparam int ENTRY_CNT_W = 5;

  typedef logic [REQ_W-1:0] req_code_t;

  localparam req_code_t REQ_SET    = 2'd0;
  localparam req_code_t REQ_GET    = 2'd1;
  localparam req_code_t REQ_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

endpackage

// File: sv/kvts_if.sv
// Request and response channel interfaces for the key/value table store.
// Depends on kvts_pkg for field widths and the status type.
interface kvts_req_if import kvts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  req_code_t             req_type;
  logic [KEY_WORD_W-1:0] key_low;
  logic [KEY_WORD_W-1:0] key_high;
  logic [VALUE_W-1:0]    value_in;

  modport source (output valid, req_type, key_low, key_high, value_in, input ready);
  modport sink   (input valid, req_type, key_low, key_high, value_in, output ready);
endinterface

interface kvts_rsp_if import kvts_pkg::*; ();
  logic                   valid;
  logic                   ready;
  status_t                status;
  logic [VALUE_W-1:0]     value_out;
  logic [ENTRY_CNT_W-1:0] entry_count;

  modport source (output valid, status, value_out, entry_count, input ready);
  modport sink   (input valid, status, value_out, entry_count, output ready);
endinterface

// File: sv/key_value_table_store.sv
// Top level of the key/value table store: slot scan, decision and write-back.
// Depends on kvts_pkg, kvts_if.sv, kvts_ram and key_value_table_store_defines.svh.
//
// Usage:
//   req carries one request beat (set, get or remove, a key of up to
//   KEY_BYTES bytes and a 64-bit value); rsp returns exactly one result beat
//   per request with a status, the value for a get and the valid entry count.
//   Keys live in one RAM and values in another, both with registered read data.
//   A request reads every slot's key in turn and compares each one in the
//   cycle after its read, while tracking the lowest free slot. A decision
//   state then writes back to the RAMs; a get that hits passes through a
//   state that reads the value RAM, and the DONE state moves the result
//   into the output register. The length of each request is set by the
//   key scan over the RAM read port. One request is in flight at a time
//   and req.ready returns with the result, so a new request can start
//   only once the previous result is in the output register.
//   Reset clears the valid bits and the count at once; RAM contents of a
//   slot that is not valid are never used, so no clearing pass is needed.
//   The output register holds its beat while rsp.ready is low; the next
//   request is accepted meanwhile and its result waits until the beat leaves.
`include "key_value_table_store_defines.svh"

module key_value_table_store import kvts_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KEY_BYTES   = KEY_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  kvts_req_if.sink   req,
  kvts_rsp_if.source rsp
);

  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [IDX_W:0] SCAN_END  = (IDX_W + 1)'(TABLE_SLOTS);
  localparam logic [IDX_W:0] SCAN_LAST = (IDX_W + 1)'(TABLE_SLOTS - 1);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    DECIDE,
    RDVAL,
    DONE
  } state_t;

  state_t                   state;
  logic [TABLE_SLOTS-1:0]   slot_valid;
  logic [CNT_W-1:0]         count;

  req_code_t                req_type;
  logic [KEY_W-1:0]         key;
  logic                     empty;
  logic [VALUE_W-1:0]       value_in;

  logic [IDX_W:0]           scan_cnt;
  logic                     cmp_vld;
  logic                     cmp_last;
  logic [IDX_W-1:0]         cmp_idx;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;
  logic                     have_free;
  logic [IDX_W-1:0]         free_idx;

  status_t                  res_status;
  logic [VALUE_W-1:0]       res_value;

  logic                     out_valid;
  status_t                  out_status;
  logic [VALUE_W-1:0]       out_value;
  logic [ENTRY_CNT_W-1:0]   out_count;

  logic [KEY_W-1:0]         key_norm;
  logic [KEY_W-1:0]         key_rdata;
  logic [VALUE_W-1:0]       val_rdata;
  logic                     key_we;
  logic                     val_we;
  logic [IDX_W-1:0]         wr_addr;
  logic [KEY_W-1:0]         key_wdata;
  logic [VALUE_W-1:0]       val_wdata;
  logic                     key_match;

  // Normalize: keep bytes up to the first zero byte, drop the rest.
  always_comb begin
    logic [2*KEY_WORD_W-1:0] raw;
    logic                    keep;
    raw  = {req.key_high, req.key_low};
    keep = 1'b1;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (raw[8*b +: 8] == 8'd0) begin
        keep = 1'b0;
      end
      key_norm[8*b +: 8] = keep ? raw[8*b +: 8] : 8'd0;
    end
  end

  assign key_match = cmp_vld && slot_valid[cmp_idx] && !empty && (key_rdata == key);

  always_comb begin
    key_we    = 1'b0;
    val_we    = 1'b0;
    wr_addr   = hit_idx;
    key_wdata = key;
    val_wdata = value_in;
    if (state == DECIDE) begin
      case (req_type)
        REQ_SET: begin
          if (!empty) begin
            if (hit) begin
              val_we = 1'b1;
            end else if (have_free) begin
              key_we  = 1'b1;
              val_we  = 1'b1;
              wr_addr = free_idx;
            end
          end
        end
        REQ_REMOVE: begin
          if (hit) begin
            key_we    = 1'b1;
            val_we    = 1'b1;
            key_wdata = '0;
            val_wdata = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  kvts_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key_wdata),
    .raddr (scan_cnt[IDX_W-1:0]),
    .rdata (key_rdata)
  );

  kvts_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_SLOTS)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (wr_addr),
    .wdata (val_wdata),
    .raddr (hit_idx),
    .rdata (val_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      slot_valid <= '0;
      count      <= '0;
      cmp_vld    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req.valid) begin
            req_type  <= req.req_type;
            key       <= key_norm;
            empty     <= (req.key_low[7:0] == 8'd0);
            value_in  <= req.value_in;
            scan_cnt  <= '0;
            cmp_vld   <= 1'b0;
            hit       <= 1'b0;
            hit_idx   <= '0;
            have_free <= 1'b0;
            free_idx  <= '0;
            state     <= SCAN;
          end
        end
        SCAN: begin
          if (scan_cnt != SCAN_END) begin
            cmp_vld  <= 1'b1;
            cmp_idx  <= scan_cnt[IDX_W-1:0];
            cmp_last <= (scan_cnt == SCAN_LAST);
            scan_cnt <= scan_cnt + 1'b1;
          end else begin
            cmp_vld <= 1'b0;
          end
          if (cmp_vld) begin
            if (key_match && !hit) begin
              hit     <= 1'b1;
              hit_idx <= cmp_idx;
            end
            if (!slot_valid[cmp_idx] && !have_free) begin
              have_free <= 1'b1;
              free_idx  <= cmp_idx;
            end
            if (cmp_last) begin
              state <= DECIDE;
            end
          end
        end
        DECIDE: begin
          res_value <= '0;
          case (req_type)
            REQ_SET: begin
              state <= DONE;
              if (empty) begin
                res_status <= ST_EMPTY;
              end else if (hit) begin
                res_status <= ST_OK;
              end else if (have_free) begin
                res_status           <= ST_OK;
                slot_valid[free_idx] <= 1'b1;
                count                <= count + 1'b1;
              end else begin
                res_status <= ST_FULL;
              end
            end
            REQ_GET: begin
              res_status <= ST_NOT_FOUND;
              state      <= hit ? RDVAL : DONE;
            end
            REQ_REMOVE: begin
              state <= DONE;
              if (hit) begin
                res_status          <= ST_OK;
                slot_valid[hit_idx] <= 1'b0;
                count               <= count - 1'b1;
              end else begin
                res_status <= ST_NOT_FOUND;
              end
            end
            default: begin
              res_status <= ST_NOT_FOUND;
              state      <= DONE;
            end
          endcase
        end
        RDVAL: begin
          res_status <= ST_OK;
          res_value  <= val_rdata;
          state      <= DONE;
        end
        DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_value  <= res_value;
            out_count  <= ENTRY_CNT_W'(count);
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign req.ready       = (state == IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.value_out   = out_value;
  assign rsp.entry_count = out_count;

  `KVTS_ASSERT(a_count_matches_valid, clk, rst, $countones(slot_valid) == int'(count), "valid count out of step with valid bits")
  `KVTS_ASSERT(a_count_bound, clk, rst, int'(count) <= TABLE_SLOTS, "valid count above table size")
  `KVTS_ASSERT(a_scan_complete, clk, rst, (state == DECIDE) |-> (scan_cnt == SCAN_END), "decision before all slots scanned")
  `KVTS_ASSERT(a_hit_is_valid, clk, rst, (state == DECIDE && hit) |-> slot_valid[hit_idx], "hit on a free slot")
  `KVTS_ASSERT(a_insert_counts, clk, rst, (state == DECIDE && key_we && req_type == REQ_SET) |=> (count == $past(count) + 1'b1), "insert did not bump the count")

endmodule

// File: sv/kvts_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kvts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/sv/key_value_table_store_test.sv
// Testbench for key_value_table_store: set/get/remove traffic checked against a table predictor.
// Depends on kvts_pkg, the kvts_req_if/kvts_rsp_if interfaces and the key_value_table_store RTL.
`timescale 1ns / 1ps

module key_value_table_store_test;
  import kvts_pkg::*;

  localparam req_code_t REQ_UNUSED = 2'd3;
  localparam int POOL_KEYS = 24;
  localparam int RANDOM_REQS = 1800;
  localparam int QUIET_TAIL = 200;

  typedef logic [2*KEY_WORD_W-1:0] key_t;

  typedef struct {
    status_t                status;
    logic [VALUE_W-1:0]     value;
    logic [ENTRY_CNT_W-1:0] count;
  } table_reply_t;

  class kv_table_tracker;
    bit                 slot_used [TABLE_SLOTS_DEF];
    key_t               slot_key  [TABLE_SLOTS_DEF];
    logic [VALUE_W-1:0] slot_val  [TABLE_SLOTS_DEF];
    int unsigned        used_count;
    table_reply_t       replies_due[$];
    int                 errors;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_key[i] = '0;
        slot_val[i] = '0;
      end
      used_count = 0;
      errors = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function key_t trim_key(logic [KEY_WORD_W-1:0] lo, logic [KEY_WORD_W-1:0] hi);
      key_t raw;
      key_t trimmed;
      raw = {hi, lo};
      trimmed = '0;
      for (int pos = 0; pos < MAX_KEY_BYTES && pos < KEY_BYTES_DEF; pos++) begin
        if (raw[8*pos +: 8] == 8'd0) break;
        trimmed[8*pos +: 8] = raw[8*pos +: 8];
      end
      return trimmed;
    endfunction

    function void note_request(req_code_t op, logic [KEY_WORD_W-1:0] lo,
                               logic [KEY_WORD_W-1:0] hi, logic [VALUE_W-1:0] val);
      key_t         k;
      bit           empty;
      bit           hit;
      bit           have_free;
      int           hit_idx;
      int           free_idx;
      table_reply_t r;
      k = trim_key(lo, hi);
      empty = (k[7:0] == 8'd0);
      hit = 1'b0;
      have_free = 1'b0;
      hit_idx = 0;
      free_idx = 0;
      r.status = ST_NOT_FOUND;
      r.value = '0;
      for (int i = 0; i < TABLE_SLOTS_DEF; i++) begin
        if (slot_used[i]) begin
          if (!hit && !empty && slot_key[i] == k) begin
            hit = 1'b1;
            hit_idx = i;
          end
        end else if (!have_free) begin
          have_free = 1'b1;
          free_idx = i;
        end
      end
      case (op)
        REQ_SET: begin
          if (empty) begin
            r.status = ST_EMPTY;
          end else if (hit) begin
            slot_val[hit_idx] = val;
            r.status = ST_OK;
          end else if (have_free) begin
            slot_used[free_idx] = 1'b1;
            slot_key[free_idx] = k;
            slot_val[free_idx] = val;
            used_count++;
            r.status = ST_OK;
          end else begin
            r.status = ST_FULL;
          end
        end
        REQ_GET: begin
          if (hit) begin
            r.value = slot_val[hit_idx];
            r.status = ST_OK;
          end
        end
        REQ_REMOVE: begin
          if (hit) begin
            slot_used[hit_idx] = 1'b0;
            slot_key[hit_idx] = '0;
            slot_val[hit_idx] = '0;
            if (used_count > 0) used_count--;
            r.status = ST_OK;
          end
        end
        default: ;
      endcase
      r.count = used_count[ENTRY_CNT_W-1:0];
      replies_due.push_back(r);
    endfunction

    function void check_reply(status_t st, logic [VALUE_W-1:0] val,
                              logic [ENTRY_CNT_W-1:0] cnt);
      table_reply_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("result with nothing expected: status %0d value %h count %0d",
                         st, val, cnt));
        return;
      end
      want = replies_due.pop_front();
      if (st !== want.status)
        report($sformatf("status expected %0d, got %0d", want.status, st));
      if (val !== want.value)
        report($sformatf("value_out expected %h, got %h", want.value, val));
      if (cnt !== want.count)
        report($sformatf("entry_count expected %0d, got %0d", want.count, cnt));
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idle_enable;

  kvts_req_if req_bus ();
  kvts_rsp_if rsp_bus ();

  kv_table_tracker tracker = new();

  key_value_table_store uut (
    .clk(clk),
    .rst(rst),
    .req(req_bus.sink),
    .rsp(rsp_bus.source)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_request(req_code_t op, logic [KEY_WORD_W-1:0] lo,
                              logic [KEY_WORD_W-1:0] hi, logic [VALUE_W-1:0] val);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= op;
    req_bus.key_low  <= lo;
    req_bus.key_high <= hi;
    req_bus.value_in <= val;
    do @(posedge clk); while (!req_bus.ready);
    tracker.note_request(op, lo, hi, val);
  endtask

  task automatic wait_for_drain();
    req_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int stall_left;
    rsp_bus.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rsp_bus.valid && rsp_bus.ready)
        tracker.check_reply(rsp_bus.status, rsp_bus.value_out, rsp_bus.entry_count);
      if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 16);
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    key_t                  key_pool [POOL_KEYS];
    int                    key_len  [POOL_KEYS];
    key_t                  k;
    int                    idx;
    int                    pick;
    req_code_t             op;
    logic [KEY_WORD_W-1:0] all_ones;

    all_ones = '1;
    idle_enable = 1'b0;
    rst <= 1'b1;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_SET;
    req_bus.key_low  <= '0;
    req_bus.key_high <= '0;
    req_bus.value_in <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (key_pool[i]) begin
      pick = $urandom_range(0, 5);
      key_len[i] = (pick == 0) ? 1 : (pick == 1) ? MAX_KEY_BYTES : $urandom_range(1, 16);
      key_pool[i] = '0;
      for (int b = 0; b < key_len[i]; b++) key_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
    end

    send_request(REQ_GET, 64'h41, '0, '0);
    send_request(REQ_SET, '0, '0, 64'h1234);
    send_request(REQ_SET, 64'hFFFF_FFFF_FFFF_FF00, all_ones, 64'h5555);
    send_request(REQ_SET, all_ones, all_ones, all_ones);
    send_request(REQ_GET, all_ones, all_ones, '0);
    send_request(REQ_SET, 64'hFFFF_FFFF_FFFF_0041, all_ones, 64'hA5A5_A5A5_5A5A_5A5A);
    send_request(REQ_GET, 64'h41, '0, all_ones);
    send_request(REQ_SET, 64'h41, '0, '0);
    send_request(REQ_GET, 64'h0000_7700_0000_0041, 64'h99, '0);
    send_request(REQ_REMOVE, '0, all_ones, '0);
    send_request(REQ_GET, '0, '0, '0);
    send_request(REQ_UNUSED, all_ones, all_ones, all_ones);
    send_request(REQ_GET, all_ones, '0, '0);
    send_request(REQ_SET, all_ones, '0, 64'h8000_0000_0000_0001);
    send_request(REQ_GET, all_ones, '0, '0);
    send_request(REQ_REMOVE, 64'h41, '0, '0);
    send_request(REQ_REMOVE, 64'h41, '0, '0);
    send_request(REQ_REMOVE, all_ones, all_ones, '0);
    send_request(REQ_GET, all_ones, all_ones, '0);
    wait_for_drain();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      idle_enable = (n >= 50 && n < RANDOM_REQS - QUIET_TAIL);
      if (n == RANDOM_REQS / 2) wait_for_drain();
      idx = $urandom_range(0, POOL_KEYS - 1);
      k = key_pool[idx];
      if (key_len[idx] < MAX_KEY_BYTES - 1 && $urandom_range(0, 3) == 0)
        for (int b = key_len[idx] + 1; b < MAX_KEY_BYTES; b++)
          k[8*b +: 8] = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 45) op = REQ_SET;
      else if (pick < 72) op = REQ_GET;
      else if (pick < 92) op = REQ_REMOVE;
      else begin
        op = req_code_t'($urandom_range(0, 3));
        if (pick < 96) begin
          k = {$urandom, $urandom, $urandom, $urandom};
          k[7:0] = 8'd0;
        end else begin
          k = {$urandom, $urandom, $urandom, $urandom};
        end
      end
      send_request(op, k[KEY_WORD_W-1:0], k[2*KEY_WORD_W-1:KEY_WORD_W], {$urandom, $urandom});
    end
    idle_enable = 1'b0;

    wait_for_drain();
    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
